FILE: rtl/core/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Payload structs, status codes, register indexes and timing constants.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned DIST_W   = 10;
  localparam int unsigned AVG_W    = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned TRIG_LOW_TICKS  = 4;
  localparam int unsigned TRIG_HIGH_TICKS = 10;
  localparam int unsigned ROUNDTRIP_TICKS = 58;
  localparam int unsigned MIN_VALID       = 3;

  // floor(x / 58) == (x * 72316) >> 22 for every 16-bit x
  localparam int unsigned DIV58_RECIP = 72316;
  localparam int unsigned DIV58_SHIFT = 22;
  localparam int unsigned RECIP_W     = 17;

  localparam logic [TICK_W-1:0] PING_TIMEOUT_RST = TICK_W'(6000);
  localparam logic [DIST_W-1:0] MAX_DIST_RST     = DIST_W'(500);

  localparam logic [CFG_IDX_W-1:0] CFG_PING_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ECHO_BUSY    = 2'd1,
    ST_PING_TIMEOUT = 2'd2,
    ST_ECHO_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    status_e           status;
    logic [DIST_W-1:0] distance_cm;
    logic              avg_valid;
    logic [AVG_W-1:0]  avg_q4;
  } out_t;

endpackage

FILE: rtl/core/ultrasonic_echo_ranger_trimmed_mean.sv
// Top level of the ultrasonic echo ranger with trimmed-mean history.
// Depends on uer_pkg, uer_ram and uer_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per
//   microsecond tick, carrying the start request and the sampled echo level.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result transfer per input tick: trigger level, busy, done, status, last
//   distance and the trimmed mean of the history ring (Q.4, truncated).
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; index 0 is the
//   ping timeout in ticks, index 1 the maximum distance in cm. Write only
//   while no tick is in flight.
// Sequence
//   A plain tick goes from C_IDLE to C_EMIT, which registers the result
//   once the result register is free; the next tick is taken back in C_IDLE.
//   A tick that ends a good measurement stores the distance and walks the
//   ring through the single read port of the history RAM (C_WR, C_WALK,
//   C_DRAIN), then, when at least three entries are valid, runs a bit-serial
//   divider (one quotient bit per cycle, 18 bits at the default depth) before
//   C_EMIT registers the result and the next tick is taken.
//   One tick is worked on at a time.
// Reset
//   Clears the phase, counters, ring valid bits and mean at once; the RAM
//   itself needs no clearing pass. Registers return to 6000 and 500.
// Stall
//   The result register holds while out_stall_i is high; the next tick is
//   still taken and worked on, and waits at the end until the result drains.
module ultrasonic_echo_ranger_trimmed_mean #(
  parameter int unsigned HISTORY_DEPTH = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  uer_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output uer_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import uer_pkg::*;

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = DIST_W + CNT_W;
  localparam int unsigned NUM_W = SUM_W + 4;
  localparam int unsigned PROD_W = TICK_W + RECIP_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LOW, PH_HIGH, PH_CHECK, PH_WAIT, PH_MEAS
  } phase_e;

  typedef enum logic [2:0] {
    C_IDLE, C_WR, C_WALK, C_DRAIN, C_PREP, C_DIV, C_EMIT
  } ctl_e;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  ctl_e               ctl_q;
  phase_e             phase_q;
  logic [TICK_W-1:0]  tick_q;
  logic [TICK_W-1:0]  ping_q;
  logic [DIST_W-1:0]  maxd_q;

  logic               res_trig_q;
  logic               res_busy_q;
  logic               res_done_q;
  status_e            res_status_q;

  logic [PROD_W-1:0]  prod_q;
  logic [AW-1:0]      slot_q;
  logic [HISTORY_DEPTH-1:0] hist_valid_q;
  logic [DIST_W-1:0]  last_dist_q;
  logic               avg_valid_q;
  logic [AVG_W-1:0]   avg_q;

  logic [AW-1:0]      walk_addr_q;
  logic               rd_valid_q;
  logic [AW-1:0]      rd_idx_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DIST_W-1:0]  lo_q;
  logic [DIST_W-1:0]  hi_q;
  logic [CNT_W-1:0]   n_q;

  logic               out_valid_q;
  out_t               out_data_q;

  // ---------------------------------------------------------------------
  // Per-tick phase logic
  // ---------------------------------------------------------------------
  logic [TICK_W-1:0]  limit;
  logic [TICK_W-1:0]  tick_inc;
  logic [TICK_W-1:0]  tick_sat;
  phase_e             phase_d;
  logic [TICK_W-1:0]  tick_d;
  logic               trig_d;
  logic               busy_d;
  logic               done_d;
  status_e            status_d;
  logic               store_d;

  assign limit    = TICK_W'(maxd_q) * TICK_W'(ROUNDTRIP_TICKS);
  assign tick_inc = tick_q + 1'b1;
  assign tick_sat = (tick_q == '1) ? tick_q : tick_inc;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    trig_d   = 1'b0;
    busy_d   = 1'b1;
    done_d   = 1'b0;
    status_d = ST_OK;
    store_d  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (in_data_i.start_req) begin
          phase_d = PH_LOW;
          tick_d  = TICK_W'(1);
        end else begin
          busy_d = 1'b0;
        end
      end
      PH_LOW: begin
        tick_d = tick_inc;
        if (tick_inc >= TICK_W'(TRIG_LOW_TICKS)) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end
      end
      PH_HIGH: begin
        trig_d = 1'b1;
        tick_d = tick_inc;
        if (tick_inc >= TICK_W'(TRIG_HIGH_TICKS)) begin
          phase_d = PH_CHECK;
          tick_d  = '0;
        end
      end
      PH_CHECK: begin
        if (in_data_i.echo_level) begin
          done_d   = 1'b1;
          status_d = ST_ECHO_BUSY;
        end else begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end
      end
      PH_WAIT: begin
        if (in_data_i.echo_level) begin
          // rising tick counts as the first high tick
          tick_d = TICK_W'(1);
          if (limit == '0) begin
            done_d   = 1'b1;
            status_d = ST_ECHO_TIMEOUT;
          end else begin
            phase_d = PH_MEAS;
          end
        end else begin
          tick_d = tick_sat;
          if (tick_sat >= ping_q) begin
            done_d   = 1'b1;
            status_d = ST_PING_TIMEOUT;
          end
        end
      end
      PH_MEAS: begin
        if (in_data_i.echo_level) begin
          tick_d = tick_sat;
          if (tick_sat > limit) begin
            done_d   = 1'b1;
            status_d = ST_ECHO_TIMEOUT;
          end
        end else begin
          store_d = 1'b1;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
        busy_d  = 1'b0;
      end
    endcase
    if (done_d) begin
      busy_d  = 1'b0;
      phase_d = PH_IDLE;
      tick_d  = '0;
    end
  end

  // ---------------------------------------------------------------------
  // History RAM and divider
  // ---------------------------------------------------------------------
  logic [DIST_W-1:0]  dist_new;
  logic [DIST_W-1:0]  rdata;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [SUM_W-1:0]   trimmed;

  // reciprocal product: bits above the shift give count / 58
  assign dist_new = prod_q[DIV58_SHIFT +: DIST_W];

  uer_ram #(
    .WIDTH (DIST_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_q == C_WR),
    .waddr_i (slot_q),
    .wdata_i (dist_new),
    .raddr_i (walk_addr_q),
    .rdata_o (rdata)
  );

  assign trimmed   = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
  assign div_start = (ctl_q == C_PREP) && (n_q >= CNT_W'(MIN_VALID));

  uer_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({trimmed, 4'b0000}),
    .den_i   (n_q - CNT_W'(2)),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------
  // Control sequencer and registers
  // ---------------------------------------------------------------------
  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q        <= C_IDLE;
      phase_q      <= PH_IDLE;
      tick_q       <= '0;
      ping_q       <= PING_TIMEOUT_RST;
      maxd_q       <= MAX_DIST_RST;
      slot_q       <= '0;
      hist_valid_q <= '0;
      last_dist_q  <= '0;
      avg_valid_q  <= 1'b0;
      avg_q        <= '0;
      walk_addr_q  <= '0;
      rd_valid_q   <= 1'b0;
      n_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PING_TIMEOUT: ping_q <= cfg_data_i;
          CFG_MAX_DISTANCE: maxd_q <= cfg_data_i[DIST_W-1:0];
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (ctl_q != C_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      // fold in ring data arriving from the previous read
      rd_valid_q <= (ctl_q == C_WALK);
      if (rd_valid_q && hist_valid_q[rd_idx_q]) begin
        if (n_q == '0 || rdata < lo_q) lo_q <= rdata;
        if (n_q == '0 || rdata > hi_q) hi_q <= rdata;
        sum_q <= sum_q + SUM_W'(rdata);
        n_q   <= n_q + 1'b1;
      end

      case (ctl_q)
        C_IDLE: begin
          if (in_xfer) begin
            phase_q      <= phase_d;
            tick_q       <= tick_d;
            res_trig_q   <= trig_d;
            res_busy_q   <= busy_d;
            res_done_q   <= done_d;
            res_status_q <= status_d;
            prod_q       <= PROD_W'(tick_q) * PROD_W'(DIV58_RECIP);
            ctl_q        <= store_d ? C_WR : C_EMIT;
          end
        end
        C_WR: begin
          // store the new distance, advance the ring slot, clear accumulators
          last_dist_q          <= dist_new;
          hist_valid_q[slot_q] <= 1'b1;
          slot_q      <= (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
          walk_addr_q <= '0;
          sum_q       <= '0;
          n_q         <= '0;
          ctl_q       <= C_WALK;
        end
        C_WALK: begin
          rd_idx_q    <= walk_addr_q;
          walk_addr_q <= walk_addr_q + 1'b1;
          if (walk_addr_q == AW'(HISTORY_DEPTH - 1)) begin
            ctl_q <= C_DRAIN;
          end
        end
        C_DRAIN: begin
          ctl_q <= C_PREP;
        end
        C_PREP: begin
          if (n_q < CNT_W'(MIN_VALID)) begin
            avg_valid_q <= 1'b0;
            avg_q       <= '0;
            ctl_q       <= C_EMIT;
          end else begin
            ctl_q <= C_DIV;
          end
        end
        C_DIV: begin
          if (div_done) begin
            avg_valid_q <= 1'b1;
            avg_q       <= div_quo[AVG_W-1:0];
            ctl_q       <= C_EMIT;
          end
        end
        C_EMIT: begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{
              trigger_level: res_trig_q,
              busy_res:      res_busy_q,
              done_res:      res_done_q,
              status:        res_status_q,
              distance_cm:   last_dist_q,
              avg_valid:     avg_valid_q,
              avg_q4:        avg_valid_q ? avg_q : '0
            };
            ctl_q <= C_IDLE;
          end
        end
        default: begin
          ctl_q <= C_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (ctl_q != C_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: rtl/core/uer_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uer_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 10
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/uer_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies; the divisor must be nonzero.
`timescale 1ns / 1ps

module uer_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   cand;
  logic             fits;

  assign cand = {rem_q, quo_q[NUM_W-1]};
  assign fits = (cand >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // shift in the next numerator bit, subtract when the divisor fits
        rem_q <= fits ? DEN_W'(cand - {1'b0, den_q}) : cand[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/core/uer_checker.sv
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input uer_pkg::out_t out_data_o
);

  import uer_pkg::*;

  // a stalled result transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // the done tick never also reports busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.done_res && out_data_o.busy_res))
    else $error("done and busy together");

  // an error status only on the done tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == ST_OK)
    else $error("status without done");

  // the trigger pulse lies inside a measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |-> out_data_o.busy_res)
    else $error("trigger outside measurement");

  // an invalid mean reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.avg_valid |-> out_data_o.avg_q4 == '0)
    else $error("invalid mean not zero");

endmodule

bind ultrasonic_echo_ranger_trimmed_mean uer_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: verif/testbench.sv
// Self-checking testbench for ultrasonic_echo_ranger_trimmed_mean: drives microsecond ticks
// and register writes, and checks every result against a tick-level model held in a class.
// Depends on uer_pkg and the ranger RTL.
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam int unsigned RING_SLOTS   = 10;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned HOLD_AT      = 700;     // tick count at which the long hold-off starts
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned LIMIT_CYCLES = 2000000;

  // Measurement phases as seen from the pins, one tick at a time.
  typedef enum logic [2:0] {
    RNG_IDLE,
    RNG_TRIG_LO,
    RNG_TRIG_HI,
    RNG_CHECK,
    RNG_WAIT,
    RNG_ECHO
  } ping_phase_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  // Tick model of the ranger plus the queue of results it still owes.
  class ranger_scoreboard;
    logic [TICK_W-1:0] ping_limit;
    logic [DIST_W-1:0] dist_limit;
    ping_phase_e       ph;
    logic [TICK_W-1:0] tick_cnt;
    logic [DIST_W-1:0] ring [RING_SLOTS];
    bit                ring_ok [RING_SLOTS];
    int unsigned       slot;
    logic [DIST_W-1:0] last_dist;
    logic [AVG_W-1:0]  mean;
    bit                mean_ok;
    out_t              pending [$];
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
      ping_limit   = PING_TIMEOUT_RST;
      dist_limit   = MAX_DIST_RST;
      ph           = RNG_IDLE;
      tick_cnt     = '0;
      slot         = 0;
      last_dist    = '0;
      mean         = '0;
      mean_ok      = 1'b0;
      errors       = 0;
      results_seen = 0;
      for (int i = 0; i < RING_SLOTS; i++) begin
        ring[i]    = '0;
        ring_ok[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PING_TIMEOUT: ping_limit = data;
        CFG_MAX_DISTANCE: dist_limit = data[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted tick and queue the result it causes.
    function void predict_tick(in_t it);
      out_t        want;
      int unsigned lim;
      int unsigned sum;
      int unsigned n;
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
      bit          fin;
      want          = '0;
      want.busy_res = 1'b1;
      want.status   = ST_OK;
      fin           = 1'b0;
      lim           = dist_limit * ROUNDTRIP_TICKS;
      case (ph)
        RNG_IDLE: begin
          if (it.start_req) begin
            ph       = RNG_TRIG_LO;
            tick_cnt = 16'd1;
          end else begin
            want.busy_res = 1'b0;
          end
        end
        RNG_TRIG_LO: begin
          tick_cnt++;
          if (tick_cnt >= TRIG_LOW_TICKS) begin
            ph       = RNG_TRIG_HI;
            tick_cnt = '0;
          end
        end
        RNG_TRIG_HI: begin
          want.trigger_level = 1'b1;
          tick_cnt++;
          if (tick_cnt >= TRIG_HIGH_TICKS) begin
            ph       = RNG_CHECK;
            tick_cnt = '0;
          end
        end
        RNG_CHECK: begin
          if (it.echo_level) begin
            fin         = 1'b1;
            want.status = ST_ECHO_BUSY;
          end else begin
            ph       = RNG_WAIT;
            tick_cnt = '0;
          end
        end
        RNG_WAIT: begin
          if (it.echo_level) begin
            tick_cnt = 16'd1;
            if (tick_cnt > lim) begin
              fin         = 1'b1;
              want.status = ST_ECHO_TIMEOUT;
            end else begin
              ph = RNG_ECHO;
            end
          end else begin
            if (tick_cnt != 16'hFFFF) tick_cnt++;
            if (tick_cnt >= ping_limit) begin
              fin         = 1'b1;
              want.status = ST_PING_TIMEOUT;
            end
          end
        end
        RNG_ECHO: begin
          if (it.echo_level) begin
            if (tick_cnt != 16'hFFFF) tick_cnt++;
            if (tick_cnt > lim) begin
              fin         = 1'b1;
              want.status = ST_ECHO_TIMEOUT;
            end
          end else begin
            last_dist = DIST_W'(tick_cnt / ROUNDTRIP_TICKS);
            if (slot >= RING_SLOTS) slot = 0;
            ring[slot]    = last_dist;
            ring_ok[slot] = 1'b1;
            slot++;
            if (slot >= RING_SLOTS) slot = 0;
            // Drop exactly one smallest and one largest entry, even when equal.
            sum = 0;
            n   = 0;
            lo  = '0;
            hi  = '0;
            for (int i = 0; i < RING_SLOTS; i++) begin
              if (ring_ok[i]) begin
                if (n == 0 || ring[i] < lo) lo = ring[i];
                if (n == 0 || ring[i] > hi) hi = ring[i];
                sum += ring[i];
                n++;
              end
            end
            if (n < MIN_VALID) begin
              mean_ok = 1'b0;
              mean    = '0;
            end else begin
              mean_ok = 1'b1;
              mean    = AVG_W'(((sum - lo - hi) * 16) / (n - 2));
            end
            fin         = 1'b1;
            want.status = ST_OK;
          end
        end
        default: begin
          ph            = RNG_IDLE;
          tick_cnt      = '0;
          want.busy_res = 1'b0;
        end
      endcase
      if (fin) begin
        want.done_res = 1'b1;
        want.busy_res = 1'b0;
        ph            = RNG_IDLE;
        tick_cnt      = '0;
      end
      want.distance_cm = last_dist;
      want.avg_valid   = mean_ok;
      want.avg_q4      = mean_ok ? mean : '0;
      pending.push_back(want);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d, %s: expected %0d, got %0d",
                   results_seen, name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result %0d arrived with nothing pending, got %h",
                   results_seen, got);
        results_seen++;
        return;
      end
      want = pending.pop_front();
      check_field("trigger_level", 16'(want.trigger_level), 16'(got.trigger_level));
      check_field("busy_res",      16'(want.busy_res),      16'(got.busy_res));
      check_field("done_res",      16'(want.done_res),      16'(got.done_res));
      check_field("status",        16'(want.status),        16'(got.status));
      check_field("distance_cm",   16'(want.distance_cm),   16'(got.distance_cm));
      check_field("avg_valid",     16'(want.avg_valid),     16'(got.avg_valid));
      check_field("avg_q4",        16'(want.avg_q4),        16'(got.avg_q4));
      results_seen++;
    endfunction
  endclass

  // All block inputs start at known values; reset is held from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  ranger_scoreboard sb;
  int unsigned      ticks_sent = 0;
  int unsigned      burst_left = 0;
  bit               hold_req   = 1'b0;

  ultrasonic_echo_ranger_trimmed_mean #(
    .HISTORY_DEPTH(RING_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one tick and hold it until the block takes it. The sender works in
  // bursts; between bursts it usually drops valid for a random gap. The model
  // advances only on the edge that completes the transfer.
  task automatic offer(input in_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_tick(it);
    ticks_sent++;
    if (ticks_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic idle_tick();
    in_t it;
    it.start_req  = 1'b0;
    it.echo_level = 1'($urandom_range(0, 1));
    offer(it);
  endtask

  // One full measurement. The echo pin follows the phase the model is in:
  // high at the busy check if asked, low for wait_len waiting ticks, then
  // high for high_len ticks. Start is random after the first tick and must
  // be ignored; echo is random while the trigger pulse runs.
  task automatic run_ping(input bit busy_echo, input int unsigned wait_len,
                          input int unsigned high_len);
    in_t         it;
    int unsigned waited;
    int unsigned echo_ticks;
    waited        = 0;
    echo_ticks    = 0;
    it.start_req  = 1'b1;
    it.echo_level = 1'($urandom_range(0, 1));
    offer(it);
    while (sb.ph != RNG_IDLE) begin
      it.start_req = 1'($urandom_range(0, 1));
      case (sb.ph)
        RNG_CHECK: it.echo_level = busy_echo;
        RNG_WAIT: begin
          it.echo_level = (waited >= wait_len);
          waited++;
        end
        RNG_ECHO: it.echo_level = (echo_ticks < high_len);
        default:  it.echo_level = 1'($urandom_range(0, 1));
      endcase
      if (it.echo_level && (sb.ph == RNG_WAIT || sb.ph == RNG_ECHO)) echo_ticks++;
      offer(it);
    end
  endtask

  // Drop valid, let every owed result drain, then give the block time to
  // finish any ring walk before registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back, keeping valid high across the pair.
  task automatic program_ranges(input logic [CFG_DATA_W-1:0] ping_ticks,
                                input logic [DIST_W-1:0] max_cm);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_PING_TIMEOUT;
    cfg_data_i  <= ping_ticks;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_PING_TIMEOUT, ping_ticks);
    cfg_index_i <= CFG_MAX_DISTANCE;
    cfg_data_i  <= CFG_DATA_W'(max_cm);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(max_cm));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: stall patterns change every segment, and one long hold-off
  // lets the block fill up so that it has to stall the sender.
  initial begin
    stall_mode_e mode;
    int unsigned seg_left;
    int unsigned hold_left;
    mode      = STALL_NONE;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 25);
          STALL_PERIODIC: out_stall_i <= (seg_left % 5 < 2);
          default:        out_stall_i <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("ultrasonic_echo_ranger_trimmed_mean regression: fail");
    $finish;
  end

  initial begin
    int unsigned pt;
    int unsigned md;
    int unsigned lim;
    int unsigned kind;
    int unsigned k;
    int unsigned wl;
    int unsigned hl;
    int unsigned rnd_base;
    int unsigned phase_end;
    bit          be;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: a short good measurement, then plain idle ticks.
    run_ping(1'b0, 3, 70);
    idle_tick();
    idle_tick();

    // Small limits: busy echo, ping timeout, distance boundaries, echo timeout.
    settle();
    program_ranges(16'd8, 10'd2);
    run_ping(1'b1, 0, 1);
    run_ping(1'b0, 8, 1);
    run_ping(1'b0, 7, 57);
    run_ping(1'b0, 0, 58);
    run_ping(1'b0, 2, 116);   // exactly at the limit still counts as good
    run_ping(1'b0, 1, 117);

    // Zero registers: ping timeout on the first waiting tick, echo timeout
    // on the rising tick.
    settle();
    program_ranges(16'd0, 10'd0);
    run_ping(1'b0, 0, 1);
    run_ping(1'b0, 5, 1);

    // Equal values in the ring: min and max are still removed once each.
    settle();
    program_ranges(16'd1, 10'd1);
    run_ping(1'b0, 0, 58);
    run_ping(1'b0, 0, 59);
    run_ping(1'b0, 1, 58);

    // Largest ping timeout and a 1000 cm maximum distance: a long echo well inside that range.
    settle();
    program_ranges(16'hFFFF, 10'd1000);
    run_ping(1'b0, 40, 580);

    // Random phases, each under fresh register values.
    rnd_base = ticks_sent;
    while (ticks_sent - rnd_base < RANDOM_ITEMS) begin
      settle();
      kind = $urandom_range(0, 9);
      if (kind < 5)       pt = $urandom_range(1, 30);
      else if (kind < 8)  pt = $urandom_range(31, 2000);
      else if (kind == 8) pt = 65535;
      else                pt = $urandom_range(1, 3);
      kind = $urandom_range(0, 9);
      if (kind < 6)      md = $urandom_range(1, 4);
      else if (kind < 9) md = $urandom_range(5, 12);
      else               md = $urandom_range(13, 1000);
      program_ranges(CFG_DATA_W'(pt), DIST_W'(md));
      lim       = md * ROUNDTRIP_TICKS;
      phase_end = ticks_sent + PHASE_ITEMS;
      while (ticks_sent < phase_end) begin
        repeat ($urandom_range(0, 3)) idle_tick();
        be   = 1'b0;
        wl   = $urandom_range(0, (pt > 16) ? 15 : pt - 1);
        hl   = $urandom_range(1, (lim < 250) ? lim : 250);
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          be = 1'b1;
        end else if (kind < 18 && pt <= 200) begin
          wl = pt + $urandom_range(0, 2);
        end else if (kind < 28 && lim <= 600) begin
          hl = lim + $urandom_range(1, 20);
        end else if (kind < 45) begin
          // Hit a multiple of the round trip, one below, at, or one above.
          k  = $urandom_range(1, (md < 5) ? md : 5);
          hl = k * ROUNDTRIP_TICKS + $urandom_range(0, 2) - 1;
        end
        run_ping(be, wl, hl);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ultrasonic_echo_ranger_trimmed_mean regression: pass");
    end else begin
      $display("ultrasonic_echo_ranger_trimmed_mean regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/uer_pkg.sv
rtl/core/uer_ram.sv
rtl/core/uer_div.sv
rtl/core/ultrasonic_echo_ranger_trimmed_mean.sv
rtl/core/uer_checker.sv
verif/testbench.sv
